[src/bgpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgpg_pkg
// Shared types and constants of the banked GPIO pattern generator.
// ----------------------------------------------------------------------------
package bgpg_pkg;

    localparam int MAX_BANKS_DEF = 8;
    localparam int MAX_PAGES_DEF = 64;
    localparam int PIN_WIDTH     = 32;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_WR_SET = 2'd1,
        OP_WR_CLR = 2'd2,
        OP_SELECT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_BAD_BANK = 2'd1,
        STS_BUSY     = 2'd2,
        STS_BAD_PAGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_WALK,
        ST_LAST
    } state_t;

    localparam logic CFG_BANKS = 1'b0;
    localparam logic CFG_PAGES = 1'b1;

    // strobes of the mask memories
    typedef struct packed {
        logic set_we;
        logic clr_we;
        logic rd_en;
    } mem_ctl_t;

endpackage

[src/bgpg_mask_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgpg_mask_store
// Set-mask and clear-mask memories, one write port each, shared read address,
// read data registered.
// ----------------------------------------------------------------------------
module bgpg_mask_store #(
    parameter int DEPTH = bgpg_pkg::MAX_BANKS_DEF * bgpg_pkg::MAX_PAGES_DEF
) (
    input  logic                           aclk,
    input  bgpg_pkg::mem_ctl_t             ctl,
    input  logic [$clog2(DEPTH)-1:0]       waddr,
    input  logic [bgpg_pkg::PIN_WIDTH-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0]       raddr,
    output logic [bgpg_pkg::PIN_WIDTH-1:0] rd_set,
    output logic [bgpg_pkg::PIN_WIDTH-1:0] rd_clr
);

    logic [bgpg_pkg::PIN_WIDTH-1:0] set_mem [DEPTH];
    logic [bgpg_pkg::PIN_WIDTH-1:0] clr_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.set_we) begin
            set_mem[waddr] <= wdata;
        end
        if (ctl.rd_en) begin
            rd_set <= set_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clr_we) begin
            clr_mem[waddr] <= wdata;
        end
        if (ctl.rd_en) begin
            rd_clr <= clr_mem[raddr];
        end
    end

endmodule

[src/banked_gpio_pattern_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_gpio_pattern_generator
// Banked page player: ticks drive pages of the playing bank, writes fill idle
// banks, a select builds the output-enable mask and queues the next bank.
// ----------------------------------------------------------------------------
// Ticks and mask writes can be sent back to back; the page masks come out of
// the mask memories in the cycle after the transfer and then move on into the
// result register. A select of a bank walks its pages through the single read
// port of the memories, one page a cycle, and the next transfer is taken only
// once the walk is done. Any item is held off while an earlier result waits on
// m_tready. After reset the block first clears all MAX_BANKS * MAX_PAGES
// entries of both memories (512 with the default sizes), one entry a cycle,
// before s_tready rises; configuration writes are taken at all times.
module banked_gpio_pattern_generator #(
    parameter int MAX_BANKS = bgpg_pkg::MAX_BANKS_DEF,
    parameter int MAX_PAGES = bgpg_pkg::MAX_PAGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,  // bank[2:0], stop[3], page[9:4], value[41:10]
    input  logic [1:0]   s_tuser,  // operation[1:0]
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,  // set_mask[31:0], clear_mask[63:32],
                                   // enable_mask[95:64], playing_bank[99:96],
                                   // tick_total[131:100]
    output logic [2:0]   m_tuser   // status[1:0], driven[2]
);

    localparam int DEPTH = MAX_BANKS * MAX_PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = $clog2(MAX_BANKS + 1);
    localparam int PW    = $clog2(MAX_PAGES + 1);
    localparam int PINW  = bgpg_pkg::PIN_WIDTH;
    localparam logic [BW-1:0] NO_BANK = BW'(MAX_BANKS);

    function automatic logic [AW-1:0] slot_addr(input int b, input int p);
        slot_addr = AW'(b * MAX_PAGES + p);
    endfunction

    // state
    bgpg_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     clr_idx_reg, clr_idx_next;
    logic [3:0]        banks_cfg_reg;
    logic [6:0]        pages_cfg_reg;
    logic [BW-1:0]     cur_bank_reg, cur_bank_next;
    logic [BW-1:0]     pend_bank_reg, pend_bank_next;
    logic [BW-1:0]     rep_bank_reg, rep_bank_next;
    logic [PW-1:0]     ptr_reg, ptr_next;
    logic [PINW-1:0]   enables_reg, enables_next;
    logic [31:0]       total_reg, total_next;
    logic [BW-1:0]     sel_bank_reg, sel_bank_next;
    logic [PW-1:0]     walk_idx_reg, walk_idx_next;
    logic [PINW-1:0]   acc_reg, acc_next;

    // result stage waiting for memory data, then the output register
    logic                p1_valid_reg;
    logic                p1_load;
    bgpg_pkg::status_t   p1_status_reg, p1_status_next;
    logic                p1_driven_reg, p1_driven_next;
    logic [PINW-1:0]     p1_enable_reg, p1_enable_next;
    logic [3:0]          p1_bank_reg, p1_bank_next;
    logic [31:0]         p1_total_reg, p1_total_next;
    logic                p1_adv;

    logic                m_valid_reg;
    bgpg_pkg::status_t   m_status_reg;
    logic                m_driven_reg;
    logic [PINW-1:0]     m_set_reg, m_clr_reg, m_enable_reg;
    logic [3:0]          m_bank_reg;
    logic [31:0]         m_total_reg;

    // memory port
    bgpg_pkg::mem_ctl_t  mem_ctl;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [PINW-1:0]     mem_wdata;
    logic [PINW-1:0]     rd_set, rd_clr;

    // input fields
    bgpg_pkg::op_t       in_op;
    logic [2:0]          in_bank;
    logic                in_stop;
    logic [5:0]          in_page;
    logic [31:0]         in_value;
    logic                accept;

    logic [BW-1:0]       banks_eff;
    logic [PW-1:0]       pages_eff;

    logic [BW-1:0]       tick_cur, tick_rep;
    logic [PW-1:0]       tick_ptr;
    logic                tick_drive;

    assign in_op    = bgpg_pkg::op_t'(s_tuser[1:0]);
    assign in_bank  = s_tdata[2:0];
    assign in_stop  = s_tdata[3];
    assign in_page  = s_tdata[9:4];
    assign in_value = s_tdata[41:10];

    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = (state_reg == bgpg_pkg::ST_RUN) && (!p1_valid_reg || p1_adv);
    assign accept   = s_tvalid && s_tready;

    // register values clamped to the built sizes
    always_comb begin
        if (int'(banks_cfg_reg) > MAX_BANKS) begin
            banks_eff = BW'(MAX_BANKS);
        end else begin
            banks_eff = BW'(banks_cfg_reg);
        end
        if (pages_cfg_reg == 7'd0) begin
            pages_eff = PW'(1);
        end else if (int'(pages_cfg_reg) > MAX_PAGES) begin
            pages_eff = PW'(MAX_PAGES);
        end else begin
            pages_eff = PW'(pages_cfg_reg);
        end
    end

    // bank hand-over for a tick
    always_comb begin
        tick_cur = cur_bank_reg;
        tick_ptr = ptr_reg;
        tick_rep = rep_bank_reg;
        if (cur_bank_reg == NO_BANK) begin
            tick_cur = pend_bank_reg;
            tick_ptr = '0;
        end
        // end of pass: take up the pending bank
        if (tick_cur != NO_BANK && tick_ptr >= pages_eff) begin
            tick_cur = pend_bank_reg;
            tick_ptr = '0;
            tick_rep = pend_bank_reg;
        end
        tick_drive = (tick_cur != NO_BANK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            banks_cfg_reg <= 4'd2;
            pages_cfg_reg <= 7'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bgpg_pkg::CFG_BANKS: banks_cfg_reg <= cfg_wdata[3:0];
                bgpg_pkg::CFG_PAGES: pages_cfg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        cur_bank_next  = cur_bank_reg;
        pend_bank_next = pend_bank_reg;
        rep_bank_next  = rep_bank_reg;
        ptr_next       = ptr_reg;
        enables_next   = enables_reg;
        total_next     = total_reg;
        sel_bank_next  = sel_bank_reg;
        walk_idx_next  = walk_idx_reg;
        acc_next       = acc_reg;
        p1_load        = 1'b0;
        p1_status_next = bgpg_pkg::STS_OK;
        p1_driven_next = 1'b0;
        p1_enable_next = enables_reg;
        p1_bank_next   = 4'(rep_bank_reg);
        p1_total_next  = total_reg;
        mem_ctl        = '0;
        mem_waddr      = slot_addr(int'(in_bank), int'(in_page));
        mem_wdata      = in_value;
        mem_raddr      = slot_addr(int'(tick_cur), int'(tick_ptr));

        case (state_reg)
            bgpg_pkg::ST_CLEAR: begin
                mem_ctl.set_we = 1'b1;
                mem_ctl.clr_we = 1'b1;
                mem_waddr      = clr_idx_reg;
                mem_wdata      = '0;
                clr_idx_next   = clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(DEPTH - 1)) begin
                    state_next = bgpg_pkg::ST_RUN;
                end
            end
            bgpg_pkg::ST_RUN: begin
                if (accept) begin
                    case (in_op)
                        bgpg_pkg::OP_TICK: begin
                            p1_load        = 1'b1;
                            mem_ctl.rd_en  = tick_drive;
                            cur_bank_next  = tick_cur;
                            rep_bank_next  = tick_rep;
                            ptr_next       = tick_drive ? tick_ptr + PW'(1) : tick_ptr;
                            total_next     = total_reg + 32'(tick_drive);
                            p1_driven_next = tick_drive;
                            p1_bank_next   = 4'(tick_rep);
                            p1_total_next  = total_reg + 32'(tick_drive);
                        end
                        bgpg_pkg::OP_WR_SET, bgpg_pkg::OP_WR_CLR: begin
                            p1_load = 1'b1;
                            if (int'(in_bank) == int'(cur_bank_reg) ||
                                int'(in_bank) == int'(pend_bank_reg)) begin
                                p1_status_next = bgpg_pkg::STS_BUSY;
                            end else if (int'(in_bank) >= int'(banks_eff)) begin
                                p1_status_next = bgpg_pkg::STS_BAD_BANK;
                            end else if (int'(in_page) >= int'(pages_eff)) begin
                                p1_status_next = bgpg_pkg::STS_BAD_PAGE;
                            end else if (in_op == bgpg_pkg::OP_WR_SET) begin
                                mem_ctl.set_we = 1'b1;
                            end else begin
                                mem_ctl.clr_we = 1'b1;
                            end
                        end
                        bgpg_pkg::OP_SELECT: begin
                            if (in_stop) begin
                                p1_load        = 1'b1;
                                pend_bank_next = NO_BANK;
                                enables_next   = '0;
                                p1_enable_next = '0;
                            end else if (int'(in_bank) >= int'(banks_eff)) begin
                                p1_load        = 1'b1;
                                p1_status_next = bgpg_pkg::STS_BAD_BANK;
                            end else begin
                                sel_bank_next = BW'(in_bank);
                                state_next    = bgpg_pkg::ST_DRAIN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bgpg_pkg::ST_DRAIN: begin
                // the walk reuses the read data registers
                if (!p1_valid_reg) begin
                    walk_idx_next = '0;
                    state_next    = bgpg_pkg::ST_WALK;
                end
            end
            bgpg_pkg::ST_WALK: begin
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = slot_addr(int'(sel_bank_reg), int'(walk_idx_reg));
                acc_next      = (walk_idx_reg == '0) ? '0 : (acc_reg | rd_set | rd_clr);
                walk_idx_next = walk_idx_reg + PW'(1);
                if (walk_idx_reg == pages_eff - PW'(1)) begin
                    state_next = bgpg_pkg::ST_LAST;
                end
            end
            bgpg_pkg::ST_LAST: begin
                p1_load        = 1'b1;
                enables_next   = acc_reg | rd_set | rd_clr;
                p1_enable_next = acc_reg | rd_set | rd_clr;
                pend_bank_next = sel_bank_reg;
                state_next     = bgpg_pkg::ST_RUN;
            end
            default: begin
                state_next = bgpg_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bgpg_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            cur_bank_reg  <= NO_BANK;
            pend_bank_reg <= NO_BANK;
            rep_bank_reg  <= NO_BANK;
            ptr_reg       <= '0;
            enables_reg   <= '0;
            total_reg     <= '0;
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            cur_bank_reg  <= cur_bank_next;
            pend_bank_reg <= pend_bank_next;
            rep_bank_reg  <= rep_bank_next;
            ptr_reg       <= ptr_next;
            enables_reg   <= enables_next;
            total_reg     <= total_next;
            if (p1_load) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sel_bank_reg <= sel_bank_next;
        walk_idx_reg <= walk_idx_next;
        acc_reg      <= acc_next;
        if (p1_load) begin
            p1_status_reg <= p1_status_next;
            p1_driven_reg <= p1_driven_next;
            p1_enable_reg <= p1_enable_next;
            p1_bank_reg   <= p1_bank_next;
            p1_total_reg  <= p1_total_next;
        end
        if (p1_adv) begin
            m_status_reg <= p1_status_reg;
            m_driven_reg <= p1_driven_reg;
            m_set_reg    <= p1_driven_reg ? rd_set : '0;
            m_clr_reg    <= p1_driven_reg ? rd_clr : '0;
            m_enable_reg <= p1_enable_reg;
            m_bank_reg   <= p1_bank_reg;
            m_total_reg  <= p1_total_reg;
        end
    end

    bgpg_mask_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk   (aclk),
        .ctl    (mem_ctl),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr  (mem_raddr),
        .rd_set (rd_set),
        .rd_clr (rd_clr)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_total_reg, m_bank_reg, m_enable_reg, m_clr_reg, m_set_reg};
    assign m_tuser  = {m_driven_reg, m_status_reg};

    // reads and writes of the mask memories never share a cycle
    a_mem_port: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_ctl.rd_en |-> !(mem_ctl.set_we || mem_ctl.clr_we))
        else $error("mask memory read and write in the same cycle");

    // a finished select lands in an empty result stage
    a_walk_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bgpg_pkg::ST_LAST |-> !p1_valid_reg)
        else $error("select result would overwrite a waiting result");

    // a driven page always reports ok
    a_drive_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_driven_reg |-> m_status_reg == bgpg_pkg::STS_OK)
        else $error("driven result with error status");

    // the drive count moves only on an accepted tick
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg != $past(total_reg) |-> $past(accept && in_op == bgpg_pkg::OP_TICK))
        else $error("drive count changed without a tick");

endmodule
